FILE: hw/rtl/msfr_pkg.sv
`timescale 1ns / 1ps

package msfr_pkg;

    localparam int FRAME_LEN   = 7;
    localparam int STORE_DEPTH = FRAME_LEN - 1;
    localparam int CNT_W       = 3;

    localparam logic [7:0] HEADER_RESET    = 8'd165;
    localparam logic [7:0] SPEED_CMD_RESET = 8'd2;

    typedef enum logic [0:0] {
        REG_HEADER    = 1'b0,
        REG_SPEED_CMD = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_SPEED_OK   = 2'd0,
        STATUS_BAD_HEADER = 2'd1,
        STATUS_BAD_SUM    = 2'd2,
        STATUS_OTHER_CMD  = 2'd3
    } frame_status_t;

    typedef struct packed {
        frame_status_t      frame_status;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
    } frame_result_t;

endpackage

FILE: hw/rtl/msfr_byte_if.sv
`timescale 1ns / 1ps

interface msfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/msfr_result_if.sv
`timescale 1ns / 1ps

interface msfr_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_status;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;

    modport source (output valid, output frame_status, output left_speed,
                    output right_speed, input ready);
    modport sink (input valid, input frame_status, input left_speed,
                  input right_speed, output ready);
endinterface

FILE: hw/rtl/motor_speed_frame_receiver_core.sv
`timescale 1ns / 1ps

// Receives UART bytes and assembles 7-byte frames (header, command, left speed
// MSB/LSB, right speed MSB/LSB, 8-bit sum of the first six bytes). Accepts one
// byte per cycle; each byte is judged while it sits in the input register, and a
// frame's result is registered in the output register when its seventh byte is
// judged. One result transaction per completed frame carries the status and
// the held speeds; the input side stalls only while a result waits in the
// output register and the next byte is ready to be processed. The header and
// speed command registers are written through cfg_we/cfg_index/cfg_wdata.

module motor_speed_frame_receiver_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  msfr_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_wdata,
    msfr_byte_if.sink           byte_ch,
    msfr_result_if.source       result_ch
);
    import msfr_pkg::*;

    logic [7:0]    header_reg;
    logic [7:0]    speed_cmd_reg;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;

    logic          out_valid_reg;
    frame_result_t out_reg;

    logic          fire;
    logic          done;
    frame_result_t result;

    assign fire          = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign byte_ch.ready = !in_valid_reg || fire;

    msfr_assembler u_assembler (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .rx_byte       (in_byte_reg),
        .header_byte   (header_reg),
        .speed_command (speed_cmd_reg),
        .done          (done),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= HEADER_RESET;
            speed_cmd_reg <= SPEED_CMD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADER:    header_reg    <= cfg_wdata;
                REG_SPEED_CMD: speed_cmd_reg <= cfg_wdata;
                default:       header_reg    <= header_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ch.ready)
            begin
                in_valid_reg <= byte_ch.valid;
            end
            if (fire && done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            in_byte_reg <= byte_ch.rx_byte;
        end
        if (fire && done)
        begin
            out_reg <= result;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.frame_status = out_reg.frame_status;
    assign result_ch.left_speed   = out_reg.left_speed;
    assign result_ch.right_speed  = out_reg.right_speed;

endmodule

FILE: hw/rtl/msfr_assembler.sv
`timescale 1ns / 1ps

module msfr_assembler (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic [7:0]             rx_byte,
    input  logic [7:0]             header_byte,
    input  logic [7:0]             speed_command,
    output logic                   done,
    output msfr_pkg::frame_result_t result
);
    import msfr_pkg::*;

    logic [7:0]       store_reg [STORE_DEPTH];
    logic [7:0]       store_next [STORE_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      left_reg, left_next;
    logic [15:0]      right_reg, right_next;

    logic             restart;
    logic [CNT_W-1:0] eff_cnt;
    logic [7:0]       sum;
    frame_status_t    status;

    always_comb
    begin
        restart = (rx_byte == header_byte) && (store_reg[0] != header_byte);
        eff_cnt = restart ? '0 : cnt_reg;
        done    = (eff_cnt == CNT_W'(STORE_DEPTH));

        sum = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            sum = sum + store_reg[i];
        end

        if (store_reg[0] != header_byte)
        begin
            status = STATUS_BAD_HEADER;
        end
        else if (sum != rx_byte)
        begin
            status = STATUS_BAD_SUM;
        end
        else if (store_reg[1] == speed_command)
        begin
            status = STATUS_SPEED_OK;
        end
        else
        begin
            status = STATUS_OTHER_CMD;
        end
    end

    always_comb
    begin
        store_next = store_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        right_next = right_reg;
        if (fire)
        begin
            if (done)
            begin
                for (int i = 0; i < STORE_DEPTH; i++)
                begin
                    store_next[i] = '0;
                end
                cnt_next = '0;
                if (status == STATUS_SPEED_OK)
                begin
                    left_next  = {store_reg[2], store_reg[3]};
                    right_next = {store_reg[4], store_reg[5]};
                end
            end
            else
            begin
                for (int i = 0; i < STORE_DEPTH; i++)
                begin
                    if (eff_cnt == CNT_W'(i))
                    begin
                        store_next[i] = rx_byte;
                    end
                end
                cnt_next = eff_cnt + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        result.frame_status = status;
        result.left_speed   = left_next;
        result.right_speed  = right_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
            cnt_reg   <= '0;
            left_reg  <= '0;
            right_reg <= '0;
        end
        else
        begin
            store_reg <= store_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

endmodule

FILE: tb/motor_speed_frame_receiver_core_tb.sv
`timescale 1ns / 1ps

module motor_speed_frame_receiver_core_tb;

    import msfr_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_PRINTS    = 50;

    localparam int IDLE_NONE   = 0;
    localparam int IDLE_FULL   = 1;
    localparam int IDLE_BURSTY = 2;

    typedef struct {
        logic [7:0] value;
        int         gap;
    } byte_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    cfg_index_t cfg_index = REG_HEADER;
    logic [7:0] cfg_wdata = 8'h00;

    logic       drv_valid = 1'b0;
    logic [7:0] drv_byte = 8'h00;
    logic       snk_ready = 1'b0;

    msfr_byte_if   byte_ch ();
    msfr_result_if result_ch ();

    assign byte_ch.valid   = drv_valid;
    assign byte_ch.rx_byte = drv_byte;
    assign result_ch.ready = snk_ready;

    motor_speed_frame_receiver_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    always #1 clk = ~clk;

    // frame model state
    logic [7:0]         active_header    = HEADER_RESET;
    logic [7:0]         active_speed_cmd = SPEED_CMD_RESET;
    logic [7:0]         frame_store [FRAME_LEN];
    int                 store_fill = 0;
    logic signed [15:0] left_held  = '0;
    logic signed [15:0] right_held = '0;
    frame_result_t      expected_frames [$];

    byte_item_t pending_bytes [$];
    byte_item_t drv_head;
    frame_result_t want;

    int  src_idle = IDLE_BURSTY;
    int  snk_idle = IDLE_BURSTY;
    bit  hold_off = 1'b0;
    int  gap_count = 0;
    int  stall_left = 0;
    int  queued_total = 0;
    int  bytes_accepted = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  settings_written = 0;
    int  cycle_count = 0;
    int  status_seen [4];

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int draw_gap(input int mode);
        case (mode)
            IDLE_NONE:   draw_gap = 0;
            IDLE_FULL:   draw_gap = $urandom_range(0, 16);
            default:     draw_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        endcase
    endfunction

    // one byte into the frame model; a completed frame yields one expected result
    task automatic judge_rx_byte(input logic [7:0] b);
        frame_result_t outcome;
        logic [7:0]    sum;
        int            k;
        if (b == active_header && frame_store[0] != active_header)
            store_fill = 0;
        frame_store[store_fill] = b;
        store_fill++;
        if (store_fill == FRAME_LEN)
        begin
            sum = 8'h00;
            for (k = 0; k < FRAME_LEN - 1; k++)
                sum = sum + frame_store[k];
            if (frame_store[0] != active_header)
                outcome.frame_status = STATUS_BAD_HEADER;
            else if (sum != frame_store[FRAME_LEN - 1])
                outcome.frame_status = STATUS_BAD_SUM;
            else if (frame_store[1] == active_speed_cmd)
            begin
                left_held  = {frame_store[2], frame_store[3]};
                right_held = {frame_store[4], frame_store[5]};
                outcome.frame_status = STATUS_SPEED_OK;
            end
            else
                outcome.frame_status = STATUS_OTHER_CMD;
            outcome.left_speed  = left_held;
            outcome.right_speed = right_held;
            expected_frames.push_back(outcome);
            for (k = 0; k < FRAME_LEN; k++)
                frame_store[k] = 8'h00;
            store_fill = 0;
        end
    endtask

    // byte source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_byte  <= 8'h00;
            gap_count <= 0;
        end
        else
        begin
            if (drv_valid && byte_ch.ready)
            begin
                judge_rx_byte(drv_byte);
                bytes_accepted++;
            end
            if (!drv_valid || byte_ch.ready)
            begin
                if (pending_bytes.size() == 0 || hold_off)
                    drv_valid <= 1'b0;
                else if (gap_count < pending_bytes[0].gap)
                begin
                    drv_valid <= 1'b0;
                    gap_count <= gap_count + 1;
                end
                else
                begin
                    drv_head = pending_bytes.pop_front();
                    drv_valid <= 1'b1;
                    drv_byte  <= drv_head.value;
                    gap_count <= 0;
                end
            end
        end
    end

    // result sink and compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snk_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_ch.valid && snk_ready)
            begin
                results_seen++;
                status_seen[result_ch.frame_status]++;
                if (expected_frames.size() == 0)
                    report_mismatch($sformatf("result with no frame pending, status %0d",
                                              result_ch.frame_status));
                else
                begin
                    want = expected_frames.pop_front();
                    if (result_ch.frame_status !== want.frame_status)
                        report_mismatch($sformatf("frame %0d status %0d, want %0d",
                                                  results_seen, result_ch.frame_status,
                                                  want.frame_status));
                    if (result_ch.left_speed !== want.left_speed)
                        report_mismatch($sformatf("frame %0d left_speed %0d, want %0d",
                                                  results_seen, result_ch.left_speed,
                                                  want.left_speed));
                    if (result_ch.right_speed !== want.right_speed)
                        report_mismatch($sformatf("frame %0d right_speed %0d, want %0d",
                                                  results_seen, result_ch.right_speed,
                                                  want.right_speed));
                end
                stall_left = draw_gap(snk_idle);
            end
            if (stall_left > 0)
            begin
                snk_ready <= 1'b0;
                stall_left--;
            end
            else
                snk_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_frames.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] value);
        byte_item_t item;
        item.value = value;
        item.gap   = draw_gap(src_idle);
        pending_bytes.push_back(item);
        queued_total++;
    endtask

    task automatic queue_frame(input logic [7:0] hdr, input logic [7:0] cmd,
                               input logic [15:0] lspd, input logic [15:0] rspd,
                               input logic [7:0] sum_flip, input int keep);
        logic [7:0] frame_out [FRAME_LEN];
        int         k;
        frame_out[0] = hdr;
        frame_out[1] = cmd;
        frame_out[2] = lspd[15:8];
        frame_out[3] = lspd[7:0];
        frame_out[4] = rspd[15:8];
        frame_out[5] = rspd[7:0];
        frame_out[6] = 8'h00;
        for (k = 0; k < FRAME_LEN - 1; k++)
            frame_out[6] = frame_out[6] + frame_out[k];
        frame_out[6] = frame_out[6] ^ sum_flip;
        for (k = 0; k < keep; k++)
            queue_byte(frame_out[k]);
    endtask

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 9))
            0:       pick_speed = 16'h8000;
            1:       pick_speed = 16'h7fff;
            2:       pick_speed = 16'hffff;
            3:       pick_speed = 16'h0000;
            default: pick_speed = 16'($urandom);
        endcase
    endfunction

    // mostly well-formed frames, some truncated frames and loose noise bytes
    task automatic random_phase(input int count);
        int target;
        int pick;
        @(negedge clk);
        target = queued_total + count;
        while (queued_total < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                queue_frame(($urandom_range(0, 19) == 0) ? 8'($urandom) : active_header,
                            ($urandom_range(0, 2) == 0) ? 8'($urandom) : active_speed_cmd,
                            pick_speed(), pick_speed(),
                            ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                            FRAME_LEN);
            else if (pick < 85)
                queue_frame(active_header, active_speed_cmd, pick_speed(), pick_speed(),
                            8'h00, $urandom_range(1, FRAME_LEN - 1));
            else
                repeat ($urandom_range(1, 4))
                    queue_byte(($urandom_range(0, 3) == 0) ? active_header : 8'($urandom));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || drv_valid || expected_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_HEADER)
            active_header = value;
        else
            active_speed_cmd = value;
        settings_written++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        for (int k = 0; k < FRAME_LEN; k++)
            frame_store[k] = 8'h00;
        for (int k = 0; k < 4; k++)
            status_seen[k] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        // speed frame at the extremes; checksum byte equals the header
        queue_frame(8'hA5, 8'h02, 16'h8000, 16'h7fff, 8'h00, FRAME_LEN);
        // bad header and bad checksum together
        queue_frame(8'h00, 8'h02, 16'hffff, 16'h0000, 8'hff, FRAME_LEN);
        // stray byte, header restarts, header value inside the frame, other command
        queue_byte(8'h11);
        queue_frame(8'hA5, 8'h07, 16'hA501, 16'h0000, 8'h00, FRAME_LEN);
        // checksum off by one bit
        queue_frame(8'hA5, 8'h02, 16'h1234, 16'h5678, 8'h01, FRAME_LEN);
        random_phase(200);
        wait_drained();

        src_idle = IDLE_FULL;
        snk_idle = IDLE_BURSTY;
        write_reg(REG_HEADER, 8'h00);
        write_reg(REG_SPEED_CMD, 8'hff);
        random_phase(110);
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || drv_valid);
        hold_off = 1'b1;
        random_phase(110);
        do
            @(negedge clk);
        while (expected_frames.size() != 0);
        hold_off = 1'b0;
        // leave a partial frame in the store across the register change
        queue_byte(active_header);
        queue_byte(8'h3c);
        wait_drained();

        src_idle = IDLE_BURSTY;
        snk_idle = IDLE_FULL;
        write_reg(REG_HEADER, 8'hff);
        write_reg(REG_SPEED_CMD, 8'h00);
        random_phase(200);
        wait_drained();

        src_idle = IDLE_FULL;
        snk_idle = IDLE_FULL;
        write_reg(REG_HEADER, 8'($urandom));
        write_reg(REG_SPEED_CMD, 8'($urandom));
        random_phase(250);
        wait_drained();

        src_idle = IDLE_NONE;
        snk_idle = IDLE_NONE;
        write_reg(REG_HEADER, HEADER_RESET);
        write_reg(REG_SPEED_CMD, SPEED_CMD_RESET);
        random_phase(250);
        wait_drained();

        if (expected_frames.size() != 0)
            report_mismatch($sformatf("%0d frame results never arrived",
                                      expected_frames.size()));
        $display("covered %0d bytes, %0d frames: speed %0d, bad header %0d, bad sum %0d, other %0d",
                 bytes_accepted, results_seen, status_seen[STATUS_SPEED_OK],
                 status_seen[STATUS_BAD_HEADER], status_seen[STATUS_BAD_SUM],
                 status_seen[STATUS_OTHER_CMD]);
        $display("%0d register writes, %0d mismatches", settings_written, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
